@@ src/pfa_pkg.sv @@
package pfa_pkg;

  // Field widths
  localparam int ID_W     = 16;
  localparam int SIZE_W   = 22;
  localparam int FS_W     = 16;
  localparam int CNT_W    = 7;
  localparam int FRAG_W   = 16;
  localparam int STATUS_W = 2;
  localparam int DCNT_W   = 5;

  // Configuration port
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int REG_IDX_BIT = 2;

  localparam logic REG_FRAME_SIZE   = 1'b0;
  localparam logic REG_TOTAL_FRAMES = 1'b1;

  localparam logic [FS_W-1:0]  FRAME_SIZE_RST   = 16'd1;
  localparam logic [CNT_W-1:0] TOTAL_FRAMES_RST = 7'd64;

  // Command modes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FRAMES = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SLOT_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_INVALID   = 2'd3;

  // Restoring divider runs one quotient bit per step
  localparam logic [DCNT_W-1:0] DIV_STEPS = 5'd22;

  typedef struct packed {
    logic              mode;
    logic [ID_W-1:0]   process_id;
    logic [SIZE_W-1:0] process_size;
  } pfa_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    frames_changed;
    logic [FRAG_W-1:0]   request_frag;
    logic [SIZE_W-1:0]   total_frag;
    logic [CNT_W-1:0]    free_frames;
  } pfa_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SLOT,
    ST_DECIDE,
    ST_FILL,
    ST_DSLOT,
    ST_DFRAME
  } pfa_state_t;

  // Controller to datapath
  typedef struct packed {
    logic                load;
    logic                div_step;
    logic                slot_step;
    logic                commit;
    logic                fill_step;
    logic                dslot_step;
    logic                dframe_step;
    logic                reply;
    logic [STATUS_W-1:0] code;
  } pfa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic invalid;
    logic is_delete;
    logic div_done;
    logic slot_done;
    logic slot_found;
    logic need_ok;
    logic fill_done;
    logic dslot_done;
    logic dframe_done;
  } pfa_stat_t;

endpackage

@@ src/pfa_ctrl.sv @@
module pfa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pfa_pkg::pfa_stat_t stat,
  output pfa_pkg::pfa_cmd_t  cmd
);
  import pfa_pkg::*;

  pfa_state_t state;
  pfa_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.invalid)        state_next = ST_IDLE;
        else if (stat.is_delete) state_next = ST_DSLOT;
        else                     state_next = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) state_next = ST_SLOT;
      end
      ST_SLOT: begin
        if (stat.slot_done) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (stat.need_ok && stat.slot_found) state_next = ST_FILL;
        else                                 state_next = ST_IDLE;
      end
      ST_FILL: begin
        if (stat.fill_done) state_next = ST_IDLE;
      end
      ST_DSLOT: begin
        if (stat.dslot_done) state_next = ST_DFRAME;
      end
      ST_DFRAME: begin
        if (stat.dframe_done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    cmd.code = STATUS_DONE;
    case (state)
      ST_IDLE: begin
        cmd.load = start;
      end
      ST_CHECK: begin
        if (stat.invalid) begin
          cmd.reply = 1'b1;
          cmd.code  = STATUS_INVALID;
        end
      end
      ST_DIV: begin
        cmd.div_step = !stat.div_done;
      end
      ST_SLOT: begin
        cmd.slot_step = !stat.slot_done;
      end
      ST_DECIDE: begin
        if (!stat.need_ok) begin
          cmd.reply = 1'b1;
          cmd.code  = STATUS_NO_FRAMES;
        end else if (!stat.slot_found) begin
          cmd.reply = 1'b1;
          cmd.code  = STATUS_SLOT_FULL;
        end else begin
          cmd.commit = 1'b1;
        end
      end
      ST_FILL: begin
        if (stat.fill_done) cmd.reply = 1'b1;
        else                cmd.fill_step = 1'b1;
      end
      ST_DSLOT: begin
        cmd.dslot_step = 1'b1;
      end
      ST_DFRAME: begin
        if (stat.dframe_done) cmd.reply = 1'b1;
        else                  cmd.dframe_step = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

@@ src/pfa_datapath.sv @@
module pfa_datapath #(
  parameter int NUM_FRAMES = 64,
  parameter int PROC_SLOTS = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  pfa_pkg::pfa_in_t           request,
  input  logic [pfa_pkg::FS_W-1:0]   frame_size,
  input  logic [pfa_pkg::CNT_W-1:0]  lim,
  input  logic                       cfg_clear,
  input  logic [pfa_pkg::CNT_W-1:0]  clear_total,
  input  pfa_pkg::pfa_cmd_t          cmd,
  output pfa_pkg::pfa_stat_t         stat,
  output pfa_pkg::pfa_out_t          result,
  output logic                       done
);
  import pfa_pkg::*;

  localparam int FIDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int SIDX_W = (PROC_SLOTS > 1) ? $clog2(PROC_SLOTS) : 1;
  localparam int SCNT_W = $clog2(PROC_SLOTS + 1);
  localparam logic [CNT_W-1:0]  FRAMES_N  = CNT_W'(NUM_FRAMES);
  localparam logic [SCNT_W-1:0] SLOTS_N   = SCNT_W'(PROC_SLOTS);

  // Captured command
  pfa_in_t item;

  // Divider
  logic [SIZE_W-1:0] dq;
  logic [FS_W-1:0]   rem;
  logic [DCNT_W-1:0] dcnt;
  logic [FS_W-1:0]   fs_eff;
  logic [FS_W:0]     trial;
  logic [FS_W:0]     diff;
  logic              take;
  logic              rem_nz;
  logic [SIZE_W:0]   need;
  logic [FRAG_W-1:0] rfrag;

  // Scans and totals
  logic [SCNT_W-1:0] scnt;
  logic [CNT_W-1:0]  fcnt;
  logic              slot_found;
  logic [CNT_W-1:0]  changed;
  logic [CNT_W-1:0]  free_count;
  logic [SIZE_W-1:0] frag_total;
  logic [FRAG_W-1:0] req_frag;
  logic [PROC_SLOTS-1:0] slot_used;
  logic [NUM_FRAMES-1:0] frame_used;

  // Memories
  logic [ID_W-1:0]   frame_mem [NUM_FRAMES];
  logic [ID_W-1:0]   slot_owner_mem [PROC_SLOTS];
  logic [FRAG_W-1:0] slot_frag_mem [PROC_SLOTS];
  logic [ID_W-1:0]   frame_rd;
  logic [ID_W-1:0]   s_owner_rd;
  logic [FRAG_W-1:0] s_frag_rd;
  logic              s_eval;
  logic              f_eval;
  logic [SIDX_W-1:0] s_eidx;
  logic [FIDX_W-1:0] f_eidx;

  logic [SIDX_W-1:0] sidx;
  logic [FIDX_W-1:0] fidx;
  logic s_more, f_fill_more, f_all_more;
  logic ins_slot_adv, fill_adv, fill_take, s_issue, f_issue, s_match, f_match;

  // Divide step and fragmentation
  always_comb begin
    fs_eff = (frame_size == '0) ? FS_W'(1) : frame_size;
    trial  = {rem, dq[SIZE_W-1]};
    diff   = trial - {1'b0, fs_eff};
    take   = (trial >= {1'b0, fs_eff});
    rem_nz = (rem != '0);
    need   = {1'b0, dq} + {{SIZE_W{1'b0}}, rem_nz};
    rfrag  = rem_nz ? (fs_eff - rem) : '0;
  end

  // Scan control
  always_comb begin
    sidx         = scnt[SIDX_W-1:0];
    fidx         = fcnt[FIDX_W-1:0];
    s_more       = (scnt < SLOTS_N);
    f_fill_more  = (fcnt < lim);
    f_all_more   = (fcnt < FRAMES_N);
    ins_slot_adv = cmd.slot_step && s_more && !slot_found;
    fill_adv     = cmd.fill_step && f_fill_more;
    fill_take    = fill_adv && !frame_used[fidx] && (changed != need[CNT_W-1:0]);
    s_issue      = cmd.dslot_step && s_more;
    f_issue      = cmd.dframe_step && f_all_more;
    s_match      = s_eval && slot_used[s_eidx] && (s_owner_rd == item.process_id);
    f_match      = f_eval && frame_used[f_eidx] && (frame_rd == item.process_id);
  end

  // Capture item and run the divider
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= request;
      dq   <= request.process_size;
      rem  <= '0;
    end else if (cmd.div_step) begin
      dq  <= {dq[SIZE_W-2:0], take};
      rem <= take ? diff[FS_W-1:0] : trial[FS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.load) begin
      dcnt <= '0;
    end else if (cmd.div_step) begin
      dcnt <= dcnt + DCNT_W'(1);
    end
  end

  // Slot and frame counters
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      scnt       <= '0;
      fcnt       <= '0;
      slot_found <= 1'b0;
      changed    <= '0;
      req_frag   <= '0;
    end else begin
      if (ins_slot_adv) begin
        if (!slot_used[sidx]) slot_found <= 1'b1;
        else                  scnt <= scnt + SCNT_W'(1);
      end else if (s_issue) begin
        scnt <= scnt + SCNT_W'(1);
      end
      if (fill_adv || f_issue) fcnt <= fcnt + CNT_W'(1);
      if (fill_take || f_match) changed <= changed + CNT_W'(1);
      if (cmd.commit) req_frag <= rfrag;
    end
  end

  // Read pipeline for delete passes
  always_ff @(posedge clk) begin
    if (rst) begin
      s_eval <= 1'b0;
      f_eval <= 1'b0;
    end else begin
      s_eval <= s_issue;
      f_eval <= f_issue;
    end
  end

  always_ff @(posedge clk) begin
    s_eidx <= sidx;
    f_eidx <= fidx;
  end

  // Free frame count and fragmentation total
  always_ff @(posedge clk) begin
    if (rst) begin
      free_count <= FRAMES_N;
      frag_total <= '0;
    end else if (cfg_clear) begin
      free_count <= clear_total;
      frag_total <= '0;
    end else begin
      if (fill_take)    free_count <= free_count - CNT_W'(1);
      else if (f_match) free_count <= free_count + CNT_W'(1);
      if (cmd.commit)   frag_total <= frag_total + {{(SIZE_W-FRAG_W){1'b0}}, rfrag};
      else if (s_match) frag_total <= frag_total - {{(SIZE_W-FRAG_W){1'b0}}, s_frag_rd};
    end
  end

  // Valid bits: an entry that is not valid reads as free
  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      slot_used  <= '0;
      frame_used <= '0;
    end else begin
      if (cmd.commit) slot_used[sidx] <= 1'b1;
      else if (s_match) slot_used[s_eidx] <= 1'b0;
      if (fill_take) frame_used[fidx] <= 1'b1;
      else if (f_match) frame_used[f_eidx] <= 1'b0;
    end
  end

  // Slot memory
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      slot_owner_mem[sidx] <= item.process_id;
      slot_frag_mem[sidx]  <= rfrag;
    end
    s_owner_rd <= slot_owner_mem[sidx];
    s_frag_rd  <= slot_frag_mem[sidx];
  end

  // Frame owner memory
  always_ff @(posedge clk) begin
    if (fill_take) frame_mem[fidx] <= item.process_id;
    frame_rd <= frame_mem[fidx];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.reply) begin
      result.status         <= cmd.code;
      result.frames_changed <= changed;
      result.request_frag   <= req_frag;
      result.total_frag     <= frag_total;
      result.free_frames    <= free_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.reply;
    end
  end

  // Status to controller
  always_comb begin
    stat.invalid     = (item.process_id == '0) ||
                       ((item.mode == MODE_INSERT) && (item.process_size == '0));
    stat.is_delete   = (item.mode == MODE_DELETE);
    stat.div_done    = (dcnt == DIV_STEPS);
    stat.slot_done   = slot_found || !s_more;
    stat.slot_found  = slot_found;
    stat.need_ok     = (need <= {{(SIZE_W+1-CNT_W){1'b0}}, free_count});
    stat.fill_done   = (changed == need[CNT_W-1:0]) || !f_fill_more;
    stat.dslot_done  = !s_more && !s_eval;
    stat.dframe_done = !f_all_more && !f_eval;
  end

endmodule

@@ src/paging_frame_allocator.sv @@
// From the accepting edge to the done strobe: an invalid command ends in the check state; an
// insert runs the 22-step restoring divider, then the slot scan up to the first free slot,
// then the frame scan up to lim frames; rejections end after the slot scan; a delete scans
// every slot and then every frame, one memory read per slot and frame. One command at a
// time: busy drops as done rises, so the next item is taken at the edge that ends the done
// cycle. Synchronous reset and any register write clear all stores at once through
// per-entry valid bits; there is no clearing pass. done lasts one cycle and cannot stall.
module paging_frame_allocator #(
  parameter int NUM_FRAMES = 64,
  parameter int PROC_SLOTS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  pfa_pkg::pfa_in_t             request,
  output logic                         done,
  output pfa_pkg::pfa_out_t            result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pfa_pkg::ADDR_W-1:0]   paddr,
  input  logic [pfa_pkg::DATA_W-1:0]   pwdata,
  output logic [pfa_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import pfa_pkg::*;

  localparam logic [CNT_W-1:0] FRAMES_N = CNT_W'(NUM_FRAMES);

  logic [FS_W-1:0]  frame_size;
  logic [CNT_W-1:0] total_frames;
  logic             reg_sel;
  logic             wr;
  logic [CNT_W-1:0] wr_total;
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] clear_total;
  pfa_cmd_t         cmd;
  pfa_stat_t        stat;

  assign pready  = 1'b1;
  assign reg_sel = paddr[REG_IDX_BIT];
  assign wr      = psel && penable && pwrite && pready;

  // Clamp the frame count to the frames built
  always_comb begin
    wr_total    = pwdata[CNT_W-1:0];
    lim         = (total_frames > FRAMES_N) ? FRAMES_N : total_frames;
    clear_total = lim;
    if (reg_sel == REG_TOTAL_FRAMES) begin
      clear_total = (wr_total > FRAMES_N) ? FRAMES_N : wr_total;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_size   <= FRAME_SIZE_RST;
      total_frames <= TOTAL_FRAMES_RST;
    end else if (wr) begin
      if (reg_sel == REG_FRAME_SIZE) frame_size <= pwdata[FS_W-1:0];
      else                          total_frames <= wr_total;
    end
  end

  // Register read
  always_comb begin
    if (reg_sel == REG_TOTAL_FRAMES) prdata = {{(DATA_W-CNT_W){1'b0}}, total_frames};
    else                             prdata = {{(DATA_W-FS_W){1'b0}}, frame_size};
  end

  pfa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  pfa_datapath #(
    .NUM_FRAMES (NUM_FRAMES),
    .PROC_SLOTS (PROC_SLOTS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .request     (request),
    .frame_size  (frame_size),
    .lim         (lim),
    .cfg_clear   (wr),
    .clear_total (clear_total),
    .cmd         (cmd),
    .stat        (stat),
    .result      (result),
    .done        (done)
  );

  // A result only follows a command in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a command in progress");

  // An accepted command holds the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not start");

  // A rejected command grants nothing
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != STATUS_DONE)) |->
      ((result.frames_changed == '0) && (result.request_frag == '0)))
    else $error("rejected command changed frames or fragmentation");

  // Free frames never exceed the frames built
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.free_frames <= FRAMES_N))
    else $error("free frame count out of range");

endmodule
